// ===== sv/sllp_pkg.sv =====
// shared types and constants of the serial line and pixel loader
`timescale 1ns / 1ps
package sllp_pkg;

  // input action codes
  localparam logic [2:0] ACT_BYTE  = 3'd0;
  localparam logic [2:0] ACT_TICK  = 3'd1;
  localparam logic [2:0] ACT_BEGIN = 3'd2;
  localparam logic [2:0] ACT_DONE  = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  // special bytes
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  // configuration register map
  localparam int         CFG_AW    = 4;
  localparam logic [1:0] REG_ECHO  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_TMO   = 2'd2;

  localparam logic        ECHO_RESET  = 1'b0;
  localparam logic [9:0]  COUNT_RESET = 10'd8;
  localparam logic [15:0] TMO_RESET   = 16'd5000;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_BYTE,
    OP_TICK,
    OP_BEGIN,
    OP_DONE,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    K_ECHO    = 3'd0,
    K_PROMPT  = 3'd1,
    K_CHAR    = 3'd2,
    K_ACK     = 3'd3,
    K_TIMEOUT = 3'd4,
    K_PIXEL   = 3'd5,
    K_INDEX   = 3'd6
  } kind_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
    logic       is_cr;
    logic       is_print;
    logic [8:0] pixel_index;
  } cmd_t;

  typedef struct packed {
    logic        echo_enable;
    logic [9:0]  pixel_count;
    logic [15:0] timeout_ms;
  } cfg_t;

endpackage

// ===== sv/serial_line_and_pixel_loader_top.sv =====
// top level: configuration registers, front end, command queue and back end
// first result is registered; a line hand-out gives one result per character
// and then an acknowledge; the back end takes no new transaction until it has
// emitted every result of the last, and the queue holds up to two meanwhile
// after reset a clearing pass zeroes the pixel memory, no item is taken
// during it while configuration writes are
`timescale 1ns / 1ps
module serial_line_and_pixel_loader_top #(
  parameter int PIXEL_CAPACITY   = 512,
  parameter int LINE_BUFFER_SIZE = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sllp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  action,
  input  logic [7:0]                  rx_byte,
  input  logic [8:0]                  pixel_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  kind,
  output logic [23:0]                 data,
  output logic                        last
);

  sllp_pkg::cfg_t cfg;
  sllp_pkg::cmd_t push_cmd;
  sllp_pkg::cmd_t pop_cmd;
  logic           push_valid;
  logic           push_ready;
  logic           pop_valid;
  logic           pop_ready;
  logic           clearing;
  logic [1:0]     reg_sel;
  logic           cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_enable <= sllp_pkg::ECHO_RESET;
      cfg.pixel_count <= sllp_pkg::COUNT_RESET;
      cfg.timeout_ms  <= sllp_pkg::TMO_RESET;
    end else if (cfg_we) begin
      case (reg_sel)
        sllp_pkg::REG_ECHO:  cfg.echo_enable <= pwdata[0];
        sllp_pkg::REG_COUNT: cfg.pixel_count <= pwdata[9:0];
        sllp_pkg::REG_TMO:   cfg.timeout_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_sel)
      sllp_pkg::REG_ECHO:  prdata = {31'd0, cfg.echo_enable};
      sllp_pkg::REG_COUNT: prdata = {22'd0, cfg.pixel_count};
      sllp_pkg::REG_TMO:   prdata = {16'd0, cfg.timeout_ms};
      default:             prdata = 32'd0;
    endcase
  end

  sllp_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .rx_byte     (rx_byte),
    .pixel_index (pixel_index),
    .hold        (clearing),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  sllp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  sllp_back #(
    .PIXEL_CAPACITY   (PIXEL_CAPACITY),
    .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .data      (data),
    .last      (last)
  );

endmodule

// ===== sv/sllp_front.sv =====
// front end: accepts input transactions and classifies them into commands
`timescale 1ns / 1ps
module sllp_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    action,
  input  logic [7:0]    rx_byte,
  input  logic [8:0]    pixel_index,
  input  logic          hold,
  output logic          push_valid,
  input  logic          push_ready,
  output sllp_pkg::cmd_t push_cmd
);

  logic known;

  // decode the action, unused codes are taken and dropped
  always_comb begin
    known             = 1'b1;
    push_cmd.op       = sllp_pkg::OP_BYTE;
    push_cmd.rx_byte  = rx_byte;
    push_cmd.is_cr    = (rx_byte == sllp_pkg::BYTE_CR);
    push_cmd.is_print = (rx_byte >= sllp_pkg::BYTE_SPACE);
    push_cmd.pixel_index = pixel_index;
    case (action)
      sllp_pkg::ACT_BYTE:  push_cmd.op = sllp_pkg::OP_BYTE;
      sllp_pkg::ACT_TICK:  push_cmd.op = sllp_pkg::OP_TICK;
      sllp_pkg::ACT_BEGIN: push_cmd.op = sllp_pkg::OP_BEGIN;
      sllp_pkg::ACT_DONE:  push_cmd.op = sllp_pkg::OP_DONE;
      sllp_pkg::ACT_READ:  push_cmd.op = sllp_pkg::OP_READ;
      default:             known = 1'b0;
    endcase
  end

  // handshake toward the queue
  assign in_ready   = push_ready && !hold;
  assign push_valid = in_valid && !hold && known;

endmodule

// ===== sv/sllp_queue.sv =====
// short command queue between the front end and the back end
`timescale 1ns / 1ps
module sllp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  sllp_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sllp_pkg::cmd_t pop_cmd
);

  localparam int QD  = sllp_pkg::QUEUE_DEPTH;
  localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);
  localparam logic [QPW-1:0] PTR_LAST = QPW'(QD - 1);
  localparam logic [QCW-1:0] CNT_FULL = QCW'(QD);

  sllp_pkg::cmd_t entries [QD];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + QPW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + QPW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

// ===== sv/sllp_back.sv =====
// back end: line store, pixel memory and result sequencer
`timescale 1ns / 1ps
module sllp_back #(
  parameter int PIXEL_CAPACITY   = 512,
  parameter int LINE_BUFFER_SIZE = 20
) (
  input  logic           clk,
  input  logic           rst,
  input  sllp_pkg::cfg_t cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  sllp_pkg::cmd_t pop_cmd,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     kind,
  output logic [23:0]    data,
  output logic           last
);

  localparam int LCAP = LINE_BUFFER_SIZE - 2;
  localparam int LAW  = (LCAP > 1) ? $clog2(LCAP) : 1;
  localparam int LLW  = $clog2(LCAP + 1);
  localparam int AW   = (PIXEL_CAPACITY > 1) ? $clog2(PIXEL_CAPACITY) : 1;
  localparam int CW   = ($clog2(PIXEL_CAPACITY + 1) > 10) ? $clog2(PIXEL_CAPACITY + 1) : 10;
  localparam logic [CW-1:0]  CAP_W    = CW'(PIXEL_CAPACITY);
  localparam logic [LLW-1:0] LCAP_W   = LLW'(LCAP);
  localparam logic [AW-1:0]  CLR_LAST = AW'(PIXEL_CAPACITY - 1);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_EVAL,
    S_TO,
    S_TAIL,
    S_HWAIT,
    S_HCH,
    S_ACK,
    S_PIX
  } state_t;

  state_t state;

  // architectural state
  logic [LLW-1:0] line_length;
  logic           command_busy;
  logic           line_waiting;
  logic           array_mode;
  logic [AW-1:0]  array_position;
  logic [1:0]     byte_ordinal;
  logic [23:0]    partial_pixel;
  logic [15:0]    elapsed_ms;

  // sequencer registers
  sllp_pkg::cmd_t   cmd;
  logic [AW-1:0]    clr_addr;
  logic [LLW-1:0]   hidx;
  logic [LLW-1:0]   hlen;
  logic             tail_pend;
  sllp_pkg::kind_t  tail_kind;
  logic [23:0]      tail_data;
  sllp_pkg::kind_t  out_kind;
  logic [23:0]      out_data;
  logic             out_last;

  // memories
  logic [7:0]  line_mem [LCAP];
  logic [7:0]  line_q;
  logic [23:0] pix_mem [PIXEL_CAPACITY];
  logic [23:0] pix_q;

  // decode of the current command
  logic [CW-1:0]  count_w;
  logic [CW-1:0]  eff;
  logic [CW-1:0]  idx_w;
  logic [CW-1:0]  pos_inc;
  logic           timed;
  logic           arr;
  logic           pix_done;
  logic           arr_end;
  logic           txt_ok;
  logic           store;
  logic           cr_len;
  logic           set_wait;
  logic           hand_b;
  logic           prompt_b;
  logic           echo_b;
  logic           hand_d;
  logic           in_range;
  logic           out_free;
  logic           is_eval_byte;
  logic           pix_we;
  logic [AW-1:0]  pix_waddr;
  logic [23:0]    pix_wdata;
  logic           line_we;

  always_comb begin
    count_w  = CW'(cfg.pixel_count);
    eff      = (count_w > CAP_W) ? CAP_W : count_w;
    idx_w    = CW'(cmd.pixel_index);
    pos_inc  = CW'(array_position) + CW'(1);
    timed    = array_mode && (elapsed_ms > cfg.timeout_ms);
    arr      = array_mode && !timed;
    pix_done = arr && (byte_ordinal == 2'd2);
    arr_end  = pix_done && (pos_inc >= eff);
    txt_ok   = !arr && !line_waiting;
    store    = txt_ok && !cmd.is_cr && cmd.is_print && (line_length < LCAP_W);
    cr_len   = txt_ok && cmd.is_cr && (line_length != '0);
    set_wait = cr_len && command_busy;
    hand_b   = cr_len && !command_busy && !timed;
    prompt_b = txt_ok && cmd.is_cr && (line_length == '0) && !command_busy;
    echo_b   = store && cfg.echo_enable;
    hand_d   = command_busy && line_waiting && (line_length != '0);
    in_range = (idx_w < eff) && (idx_w < CAP_W);
  end

  assign out_free     = !out_valid || out_ready;
  assign is_eval_byte = (state == S_EVAL) && (cmd.op == sllp_pkg::OP_BYTE);

  // memory write ports, the clearing pass shares the pixel port
  always_comb begin
    pix_we    = (state == S_CLR) || (is_eval_byte && pix_done);
    pix_waddr = (state == S_CLR) ? clr_addr : array_position;
    pix_wdata = (state == S_CLR) ? 24'd0 : {partial_pixel[23:8], cmd.rx_byte};
    line_we   = is_eval_byte && store;
  end

  // pixel memory, registered read
  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[pix_waddr] <= pix_wdata;
    end
    pix_q <= pix_mem[idx_w[AW-1:0]];
  end

  // line store, registered read
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_length[LAW-1:0]] <= cmd.rx_byte;
    end
    line_q <= line_mem[hidx[LAW-1:0]];
  end

  assign pop_ready = (state == S_IDLE);
  assign clearing  = (state == S_CLR);
  assign kind      = out_kind;
  assign data      = out_data;
  assign last      = out_last;

  // sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
      line_length    <= '0;
      command_busy   <= 1'b0;
      line_waiting   <= 1'b0;
      array_mode     <= 1'b0;
      array_position <= '0;
      byte_ordinal   <= 2'd0;
      partial_pixel  <= 24'd0;
      elapsed_ms     <= 16'd0;
      tail_pend      <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        // zero the pixel memory one entry a cycle
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (pop_valid) begin
            cmd   <= pop_cmd;
            state <= S_EVAL;
          end
        end

        // apply the command and plan its results
        S_EVAL: begin
          state     <= S_IDLE;
          tail_pend <= 1'b0;
          tail_data <= 24'd0;
          tail_kind <= sllp_pkg::K_PROMPT;
          case (cmd.op)
            sllp_pkg::OP_BYTE: begin
              if (timed) begin
                array_mode     <= 1'b0;
                array_position <= '0;
                byte_ordinal   <= 2'd0;
              end
              if (arr) begin
                case (byte_ordinal)
                  2'd0:    partial_pixel[23:16] <= cmd.rx_byte;
                  2'd1:    partial_pixel[15:8]  <= cmd.rx_byte;
                  default: partial_pixel[7:0]   <= cmd.rx_byte;
                endcase
                byte_ordinal <= (byte_ordinal == 2'd2) ? 2'd0 : byte_ordinal + 2'd1;
                if (pix_done) begin
                  if (arr_end) begin
                    array_mode     <= 1'b0;
                    array_position <= '0;
                  end else begin
                    array_position <= pos_inc[AW-1:0];
                  end
                end
              end
              if (store) begin
                line_length <= line_length + LLW'(1);
              end
              if (set_wait) begin
                line_waiting <= 1'b1;
              end
              if (echo_b) begin
                tail_kind <= sllp_pkg::K_ECHO;
                tail_data <= {16'd0, cmd.rx_byte};
              end
              tail_pend <= echo_b || prompt_b || arr_end;
              if (hand_b) begin
                hlen         <= line_length;
                hidx         <= '0;
                command_busy <= 1'b1;
                line_length  <= '0;
                line_waiting <= 1'b0;
                state        <= S_HWAIT;
              end else if (timed) begin
                state <= S_TO;
              end else if (echo_b || prompt_b || arr_end) begin
                state <= S_TAIL;
              end
            end

            sllp_pkg::OP_TICK: begin
              if (array_mode && (elapsed_ms != sllp_pkg::ELAPSED_MAX)) begin
                elapsed_ms <= elapsed_ms + 16'd1;
              end
            end

            sllp_pkg::OP_BEGIN: begin
              array_position <= '0;
              elapsed_ms     <= 16'd0;
              array_mode     <= 1'b1;
            end

            sllp_pkg::OP_DONE: begin
              if (command_busy) begin
                if (hand_d) begin
                  hlen         <= line_length;
                  hidx         <= '0;
                  line_length  <= '0;
                  line_waiting <= 1'b0;
                  state        <= S_HWAIT;
                end else begin
                  command_busy <= 1'b0;
                  tail_pend    <= 1'b1;
                  state        <= S_TAIL;
                end
              end
            end

            sllp_pkg::OP_READ: begin
              if (in_range) begin
                state <= S_PIX;
              end else begin
                tail_kind <= sllp_pkg::K_INDEX;
                tail_pend <= 1'b1;
                state     <= S_TAIL;
              end
            end

            default: state <= S_IDLE;
          endcase
        end

        // timeout error ahead of any text result
        S_TO: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= sllp_pkg::K_TIMEOUT;
            out_data  <= 24'd0;
            out_last  <= !tail_pend;
            state     <= tail_pend ? S_TAIL : S_IDLE;
          end
        end

        S_TAIL: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= tail_kind;
            out_data  <= tail_data;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end

        // line hand-out, one read and one emit per character
        S_HWAIT: state <= S_HCH;

        S_HCH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= sllp_pkg::K_CHAR;
            out_data  <= {16'd0, line_q};
            out_last  <= 1'b0;
            if (LLW'(hidx + LLW'(1)) == hlen) begin
              state <= S_ACK;
            end else begin
              hidx  <= hidx + LLW'(1);
              state <= S_HWAIT;
            end
          end
        end

        S_ACK: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= sllp_pkg::K_ACK;
            out_data  <= 24'd0;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end

        S_PIX: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= sllp_pkg::K_PIXEL;
            out_data  <= pix_q;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // a waiting line always has content and a busy command ahead of it
  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    line_waiting |-> (command_busy && (line_length != '0)))
    else $error("line waiting without busy command or content");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    line_length <= LCAP_W)
    else $error("line length beyond store size");

  a_ordinal: assert property (@(posedge clk) disable iff (rst)
    byte_ordinal != 2'd3)
    else $error("byte ordinal out of range");

  a_clr_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !out_valid)
    else $error("result during clearing pass");

  a_hand_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_HCH) |-> (hidx < hlen))
    else $error("hand-out index past line length");

endmodule
